// ===== rtl/sdp_pkg.sv =====
package sdp_pkg;

    localparam int AXIS_COUNT  = 3;
    localparam int COUNT_WIDTH = 32;
    localparam int TIME_WIDTH  = 16;
    localparam int AXIS_W      = 2;
    localparam int STEP_CNT_W  = 32;
    localparam int MAG_W       = STEP_CNT_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIR_SETUP  = 2'd0,
        CFG_PULSE_HIGH = 2'd1,
        CFG_CCW_POS    = 2'd2,
        CFG_CCW_LEVEL  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_MOVE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_SETUP = 3'b010,
        PH_HIGH  = 3'b100
    } t_phase;

    typedef struct packed {
        logic step_x;
        logic step_y;
        logic step_z;
        logic dir_x;
        logic dir_y;
        logic dir_z;
        logic busy_res;
        logic accepted;
    } t_result;

endpackage

// ===== rtl/sdp_in_if.sv =====
interface sdp_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [1:0]  axis;
    logic signed [31:0] step_count;

    modport source (output valid, output opcode, output axis, output step_count, input ready);
    modport sink   (input valid, input opcode, input axis, input step_count, output ready);
endinterface

// ===== rtl/sdp_out_if.sv =====
interface sdp_out_if;
    logic valid;
    logic ready;
    logic step_x;
    logic step_y;
    logic step_z;
    logic dir_x;
    logic dir_y;
    logic dir_z;
    logic busy_res;
    logic accepted;

    modport source (
        output valid, output step_x, output step_y, output step_z,
        output dir_x, output dir_y, output dir_z, output busy_res, output accepted,
        input ready
    );
    modport sink (
        input valid, input step_x, input step_y, input step_z,
        input dir_x, input dir_y, input dir_z, input busy_res, input accepted,
        output ready
    );
endinterface

// ===== rtl/step_dir_pulse_generator_core.sv =====
// The result of an accepted item is held in the output register from the cycle after it is taken.
// Throughput: one item per cycle; the next item is taken while a result waits,
// as long as the output register is empty or being drained in the same cycle.
// Reset (i_rst_n low, synchronous): axes idle, step and direction lines low,
// tick lengths 5, ccw_positive 0, ccw_level 1, output register empty.
module step_dir_pulse_generator_core
    import sdp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sdp_in_if.sink                i_cmd,
    sdp_out_if.source             o_res
);

    localparam logic [MAG_W-1:0] CMAX_MAG = MAG_W'((65'(1) << COUNT_WIDTH) - 65'(1));

    logic [TIME_WIDTH-1:0]  r_dir_setup;
    logic [TIME_WIDTH-1:0]  r_pulse_high;
    logic                   r_ccw_pos;
    logic                   r_ccw_level;

    t_phase                 r_phase, n_phase;
    logic [TIME_WIDTH-1:0]  r_tick, n_tick;
    logic [COUNT_WIDTH-1:0] r_steps, n_steps;
    logic [AXIS_W-1:0]      r_axis, n_axis;
    logic [AXIS_COUNT-1:0]  r_dir, n_dir;
    logic [AXIS_COUNT-1:0]  r_step, n_step;

    t_result                r_res, n_res;
    logic                   r_out_valid;

    logic                   acc;
    logic                   move_ok;
    logic [TIME_WIDTH-1:0]  lim_setup;
    logic [TIME_WIDTH-1:0]  lim_high;
    logic [TIME_WIDTH:0]    tick_inc;
    logic [COUNT_WIDTH-1:0] steps_dec;
    logic [AXIS_COUNT-1:0]  cur_bit;
    logic [AXIS_COUNT-1:0]  new_bit;
    logic                   neg;
    logic [MAG_W-1:0]       mag_full;
    logic [MAG_W-1:0]       mag_sat;
    logic                   ccw;
    logic                   level;

    assign acc         = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_out_valid || o_res.ready;

    // A zero length acts as one tick.
    assign lim_setup = (r_dir_setup == '0) ? TIME_WIDTH'(1) : r_dir_setup;
    assign lim_high  = (r_pulse_high == '0) ? TIME_WIDTH'(1) : r_pulse_high;
    assign tick_inc  = {1'b0, r_tick} + (TIME_WIDTH+1)'(1);
    assign steps_dec = (r_steps != '0) ? r_steps - COUNT_WIDTH'(1) : r_steps;
    assign cur_bit   = AXIS_COUNT'(1) << r_axis;
    assign new_bit   = AXIS_COUNT'(1) << i_cmd.axis;

    assign neg      = i_cmd.step_count[STEP_CNT_W-1];
    assign mag_full = neg ? {1'b0, STEP_CNT_W'(~i_cmd.step_count + STEP_CNT_W'(1))}
                          : {1'b0, i_cmd.step_count};
    assign mag_sat  = (mag_full > CMAX_MAG) ? CMAX_MAG : mag_full;
    assign ccw      = neg ? !r_ccw_pos : r_ccw_pos;
    assign level    = ccw ? r_ccw_level : !r_ccw_level;
    assign move_ok  = (r_phase == PH_IDLE) && (32'(i_cmd.axis) < 32'(AXIS_COUNT));

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_steps = r_steps;
        n_axis  = r_axis;
        n_dir   = r_dir;
        n_step  = r_step;
        n_res   = '0;
        if (i_cmd.opcode == OP_TICK) begin
            unique case (r_phase)
                PH_SETUP: begin
                    if (tick_inc >= {1'b0, lim_setup}) begin
                        n_tick  = '0;
                        n_step  = r_step | cur_bit;
                        n_phase = PH_HIGH;
                    end else begin
                        n_tick = tick_inc[TIME_WIDTH-1:0];
                    end
                end
                PH_HIGH: begin
                    if (tick_inc >= {1'b0, lim_high}) begin
                        n_tick  = '0;
                        n_step  = r_step & ~cur_bit;
                        n_steps = steps_dec;
                        n_phase = (steps_dec == '0) ? PH_IDLE : PH_SETUP;
                    end else begin
                        n_tick = tick_inc[TIME_WIDTH-1:0];
                    end
                end
                default: begin
                end
            endcase
        end else if (move_ok) begin
            n_res.accepted = 1'b1;
            // A zero count is taken but leaves everything as it is.
            if (mag_full != '0) begin
                n_dir   = level ? (r_dir | new_bit) : (r_dir & ~new_bit);
                n_axis  = i_cmd.axis;
                n_steps = COUNT_WIDTH'(mag_sat);
                n_tick  = '0;
                n_phase = PH_SETUP;
            end
        end
        n_res.step_x   = n_step[0];
        n_res.step_y   = n_step[1];
        n_res.step_z   = n_step[2];
        n_res.dir_x    = n_dir[0];
        n_res.dir_y    = n_dir[1];
        n_res.dir_z    = n_dir[2];
        n_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_setup  <= TIME_WIDTH'(5);
            r_pulse_high <= TIME_WIDTH'(5);
            r_ccw_pos    <= 1'b0;
            r_ccw_level  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DIR_SETUP:  r_dir_setup  <= TIME_WIDTH'(i_cfg_data);
                CFG_PULSE_HIGH: r_pulse_high <= TIME_WIDTH'(i_cfg_data);
                CFG_CCW_POS:    r_ccw_pos    <= i_cfg_data[0];
                CFG_CCW_LEVEL:  r_ccw_level  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_steps     <= '0;
            r_axis      <= '0;
            r_dir       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_steps <= n_steps;
                r_axis  <= n_axis;
                r_dir   <= n_dir;
                r_step  <= n_step;
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.step_x   = r_res.step_x;
    assign o_res.step_y   = r_res.step_y;
    assign o_res.step_z   = r_res.step_z;
    assign o_res.dir_x    = r_res.dir_x;
    assign o_res.dir_y    = r_res.dir_y;
    assign o_res.dir_z    = r_res.dir_z;
    assign o_res.busy_res = r_res.busy_res;
    assign o_res.accepted = r_res.accepted;

    a_busy_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_res.busy_res == (r_phase != PH_IDLE)))
        else $error("busy flag disagrees with phase");

    a_one_step_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_step) <= 1)
        else $error("more than one step line high");

    a_step_only_high_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> (r_phase == PH_HIGH))
        else $error("step line high outside high phase");

    a_tick_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_cmd.opcode == OP_TICK)) |=> !r_res.accepted)
        else $error("tick item flagged as accepted move");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sdp_pkg::*;

    // Tracks the step and direction lines of all axes and queues the line
    // levels expected after each accepted command item.
    class pulse_line_tracker;
        logic [15:0] setup_len;
        logic [15:0] high_len;
        logic        ccw_pos;
        logic        ccw_lvl;
        t_phase      phase;
        logic [15:0] tick_cnt;
        logic [31:0] steps_left;
        logic [1:0]  cur_axis;
        logic [2:0]  dir_lv;
        logic [2:0]  step_lv;
        t_result     pending_lines[$];
        int          errors;

        function new();
            setup_len  = 16'd5;
            high_len   = 16'd5;
            ccw_pos    = 1'b0;
            ccw_lvl    = 1'b1;
            phase      = PH_IDLE;
            tick_cnt   = '0;
            steps_left = '0;
            cur_axis   = '0;
            dir_lv     = '0;
            step_lv    = '0;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_DIR_SETUP:  setup_len = val;
                CFG_PULSE_HIGH: high_len  = val;
                CFG_CCW_POS:    ccw_pos   = val[0];
                CFG_CCW_LEVEL:  ccw_lvl   = val[0];
                default: ;
            endcase
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        // A zero length counts as one tick.
        function logic [15:0] interval_len(logic [15:0] len);
            return (len == 16'd0) ? 16'd1 : len;
        endfunction

        function bit interval_done(logic [15:0] lim);
            if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, lim}) begin
                tick_cnt = '0;
                return 1'b1;
            end
            tick_cnt = tick_cnt + 16'd1;
            return 1'b0;
        endfunction

        function void advance_tick();
            logic [2:0] sel;
            sel = 3'b001 << cur_axis;
            if (phase == PH_SETUP) begin
                if (interval_done(interval_len(setup_len))) begin
                    step_lv = step_lv | sel;
                    phase   = PH_HIGH;
                end
            end else if (phase == PH_HIGH) begin
                if (interval_done(interval_len(high_len))) begin
                    step_lv = step_lv & ~sel;
                    if (steps_left != 0)
                        steps_left = steps_left - 32'd1;
                    phase = (steps_left == 0) ? PH_IDLE : PH_SETUP;
                end
            end
        endfunction

        function bit start_move(logic [1:0] axis, logic [31:0] count);
            logic        neg;
            logic [32:0] mag;
            logic        ccw;
            logic        lvl;
            logic [2:0]  sel;
            neg = count[31];
            mag = neg ? (33'h1_0000_0000 - {1'b0, count}) : {1'b0, count};
            if (phase != PH_IDLE || axis >= AXIS_COUNT)
                return 1'b0;
            if (mag == 0)
                return 1'b1;
            if (mag > 33'h0_FFFF_FFFF)
                mag = 33'h0_FFFF_FFFF;
            ccw = neg ? !ccw_pos : ccw_pos;
            lvl = ccw ? ccw_lvl : !ccw_lvl;
            sel = 3'b001 << axis;
            dir_lv     = (dir_lv & ~sel) | (lvl ? sel : 3'b000);
            cur_axis   = axis;
            steps_left = mag[31:0];
            tick_cnt   = '0;
            phase      = PH_SETUP;
            return 1'b1;
        endfunction

        function void note_command(t_opcode op, logic [1:0] axis, logic [31:0] count);
            t_result lines;
            logic    took;
            took = 1'b0;
            if (op == OP_TICK)
                advance_tick();
            else
                took = start_move(axis, count);
            lines.step_x   = step_lv[0];
            lines.step_y   = step_lv[1];
            lines.step_z   = step_lv[2];
            lines.dir_x    = dir_lv[0];
            lines.dir_y    = dir_lv[1];
            lines.dir_z    = dir_lv[2];
            lines.busy_res = (phase != PH_IDLE);
            lines.accepted = took;
            pending_lines.push_back(lines);
        endfunction

        function void check_field(string name, logic want, logic got);
            if (got !== want) begin
                $error("%s: expected %0b, got %0b", name, want, got);
                errors++;
            end
        endfunction

        function void check_lines(t_result got);
            t_result want;
            if (pending_lines.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            want = pending_lines.pop_front();
            check_field("step_x", want.step_x, got.step_x);
            check_field("step_y", want.step_y, got.step_y);
            check_field("step_z", want.step_z, got.step_z);
            check_field("dir_x", want.dir_x, got.dir_x);
            check_field("dir_y", want.dir_y, got.dir_y);
            check_field("dir_z", want.dir_z, got.dir_z);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("accepted", want.accepted, got.accepted);
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int tx_idle_pct;
    int rx_idle_pct;

    pulse_line_tracker tracker;

    sdp_in_if  cmd_if ();
    sdp_out_if res_if ();

    step_dir_pulse_generator_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        res_if.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        t_result got;
        got.step_x   = res_if.step_x;
        got.step_y   = res_if.step_y;
        got.step_z   = res_if.step_z;
        got.dir_x    = res_if.dir_x;
        got.dir_y    = res_if.dir_y;
        got.dir_z    = res_if.dir_z;
        got.busy_res = res_if.busy_res;
        got.accepted = res_if.accepted;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            tracker.check_lines(got);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // All tasks start and end at a falling edge.
    task automatic send_item(t_opcode op, logic [1:0] axis, logic [31:0] count);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge clk);
        end
        cmd_if.valid      = 1'b1;
        cmd_if.opcode     = op;
        cmd_if.axis       = axis;
        cmd_if.step_count = count;
        @(posedge clk);
        while (cmd_if.ready !== 1'b1) @(posedge clk);
        tracker.note_command(op, axis, count);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 2'($urandom_range(3)), $urandom);
    endtask

    task automatic wait_drained();
        cmd_if.valid = 1'b0;
        while (tracker.pending_lines.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(posedge clk);
        tracker.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic finish_move();
        while (tracker.busy()) send_tick();
    endtask

    function automatic logic [15:0] pick_len();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'd1;
            default: return 16'($urandom_range(6, 1));
        endcase
    endfunction

    task automatic write_random_config();
        wait_drained();
        write_reg(CFG_DIR_SETUP, pick_len());
        write_reg(CFG_PULSE_HIGH, pick_len());
        write_reg(CFG_CCW_POS, 16'($urandom_range(1)));
        write_reg(CFG_CCW_LEVEL, 16'($urandom_range(1)));
    endtask

    // Mostly ticks and short moves; full-range counts only where the move
    // is rejected anyway, so the axes never lock up.
    task automatic send_random();
        logic [1:0]  axis;
        logic [31:0] count;
        int          mag;
        if ($urandom_range(99) < 12) begin
            axis = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            if (tracker.busy() || axis >= AXIS_COUNT) begin
                count = $urandom;
            end else begin
                mag   = ($urandom_range(4) == 0) ? $urandom_range(12, 5) : $urandom_range(4);
                count = $urandom_range(1) ? -32'(mag) : 32'(mag);
            end
            send_item(OP_MOVE, axis, count);
        end else begin
            send_tick();
        end
    endtask

    initial begin
        int leftover;
        tracker           = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_TICK;
        cmd_if.axis       = '0;
        cmd_if.step_count = '0;
        res_if.ready      = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: idle tick, bad axis, zero count.
        send_tick();
        send_item(OP_MOVE, 2'd3, 32'd7);
        send_item(OP_MOVE, 2'd0, 32'd0);

        wait_drained();
        write_reg(CFG_DIR_SETUP, 16'd0);
        write_reg(CFG_PULSE_HIGH, 16'd1);
        send_item(OP_MOVE, 2'd1, -32'sd1);
        send_item(OP_MOVE, 2'd0, 32'd4);
        finish_move();

        wait_drained();
        write_reg(CFG_CCW_POS, 16'd1);
        write_reg(CFG_CCW_LEVEL, 16'd0);
        send_item(OP_MOVE, 2'd0, -32'sd2);
        finish_move();

        // Stretch both intervals to the maximum mid-move, then shrink them.
        send_item(OP_MOVE, 2'd2, -32'sd3);
        send_tick();
        wait_drained();
        write_reg(CFG_DIR_SETUP, 16'hFFFF);
        write_reg(CFG_PULSE_HIGH, 16'hFFFF);
        repeat (3) send_tick();
        wait_drained();
        write_reg(CFG_DIR_SETUP, 16'd1);
        write_reg(CFG_PULSE_HIGH, 16'd1);
        finish_move();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 52 : 0;
            rx_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 11 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                write_random_config();
                for (int n = 0; n < 200; n++) begin
                    if ($urandom_range(99) == 0)
                        wait_drained();
                    send_random();
                end
            end
        end

        // Extreme counts last: the largest negative count keeps z busy for good.
        finish_move();
        send_item(OP_MOVE, 2'd2, 32'h8000_0000);
        send_item(OP_MOVE, 2'd0, 32'h7FFF_FFFF);
        repeat (3) send_tick();
        send_item(OP_MOVE, 2'd3, 32'hFFFF_FFFF);

        cmd_if.valid = 1'b0;
        for (int n = 0; n < 2000 && tracker.pending_lines.size() != 0; n++)
            @(negedge clk);
        repeat (4) @(negedge clk);
        leftover = tracker.pending_lines.size();
        if (leftover != 0) begin
            $error("%0d expected result items never arrived", leftover);
            tracker.errors++;
        end

        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== step_dir_pulse_generator_core.f =====
rtl/sdp_pkg.sv
rtl/sdp_in_if.sv
rtl/sdp_out_if.sv
rtl/step_dir_pulse_generator_core.sv
sim/testbench.sv
